@@ rtl/glcm_pkg.sv @@
// Shared constants, types and helper functions of the co-occurrence histogram block.
`default_nettype none

package glcm_pkg;

	// Sizing of the histogram and of the image scan.
	localparam int LEVELS      = 256;
	localparam int LEVEL_BITS  = $clog2(LEVELS);
	localparam int MAX_COLS    = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int MAX_OFFSET  = 8;
	localparam int COUNT_BITS  = 16;

	// Fixed field widths of the configuration registers and results.
	localparam int OFS_BITS    = 5;
	localparam int DIM_BITS    = 11;
	localparam int TOTAL_BITS  = 21;
	localparam int CFG_BITS    = DIM_BITS;
	localparam int REG_BITS    = 2;

	// Derived sizes.
	localparam int POS_BITS    = $clog2(MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS);
	localparam int SPOS_BITS   = DIM_BITS + 1;
	localparam int PROD_BITS   = OFS_BITS + DIM_BITS + 1;
	localparam int DIST_SBITS  = PROD_BITS + 1;
	localparam int TABLE_DEPTH = LEVELS * LEVELS;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int DELAY_DEPTH = MAX_OFFSET * MAX_COLS + MAX_OFFSET;
	localparam int DELAY_AW    = $clog2(DELAY_DEPTH);

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Configuration register indexes.
	localparam logic [REG_BITS-1:0] REG_OFFSET_ROWS = 2'd0;
	localparam logic [REG_BITS-1:0] REG_OFFSET_COLS = 2'd1;
	localparam logic [REG_BITS-1:0] REG_IMAGE_ROWS  = 2'd2;
	localparam logic [REG_BITS-1:0] REG_IMAGE_COLS  = 2'd3;

	// Command codes of an input beat.
	typedef enum logic [1:0] {
		CMD_PIXEL = 2'd0,
		CMD_READ  = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PX_CALC,
		ST_PX_SLOT,
		ST_PX_WR,
		ST_PX_INC,
		ST_RD_READ,
		ST_RD_DONE
	} state_t;

	// Configuration register set.
	typedef struct packed {
		logic signed [OFS_BITS-1:0] offset_rows;
		logic signed [OFS_BITS-1:0] offset_cols;
		logic [DIM_BITS-1:0]        image_rows;
		logic [DIM_BITS-1:0]        image_cols;
	} cfg_t;

	// Strobes from the sequencer to the scan unit.
	typedef struct packed {
		logic start;
		logic calc;
		logic step;
	} scan_ctl_t;

	// Status from the scan unit to the sequencer.
	typedef struct packed {
		logic                take;
		logic                pair_ok;
		logic                fwd;
		logic [DELAY_AW-1:0] rd_slot;
		logic [DELAY_AW-1:0] wr_slot;
	} scan_stat_t;

	// True when the offsets and image size do not describe a usable pairing.
	function automatic logic cfg_invalid(cfg_t c);
		logic [OFS_BITS-1:0] ar;
		logic [OFS_BITS-1:0] ac;
		logic                bad;
		ar = c.offset_rows[OFS_BITS-1] ? OFS_BITS'(-c.offset_rows) : c.offset_rows;
		ac = c.offset_cols[OFS_BITS-1] ? OFS_BITS'(-c.offset_cols) : c.offset_cols;
		bad = (c.image_rows == '0) || (c.image_rows > DIM_BITS'(MAX_ROWS)) ||
		      (c.image_cols == '0) || (c.image_cols > DIM_BITS'(MAX_COLS)) ||
		      ((ar == '0) && (ac == '0)) ||
		      (ar > OFS_BITS'(MAX_OFFSET)) || (ac > OFS_BITS'(MAX_OFFSET)) ||
		      (DIM_BITS'(ar) >= c.image_rows) || (DIM_BITS'(ac) >= c.image_cols);
		return bad;
	endfunction

endpackage

`default_nettype wire

@@ rtl/glcm_if.sv @@
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none

interface glcm_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      cmd;
	logic [glcm_pkg::LEVEL_BITS-1:0] pixel;
	logic [glcm_pkg::LEVEL_BITS-1:0] first_level;
	logic [glcm_pkg::LEVEL_BITS-1:0] second_level;

	modport source(output valid, cmd, pixel, first_level, second_level, input ready);
	modport sink(input valid, cmd, pixel, first_level, second_level, output ready);
endinterface

interface glcm_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [glcm_pkg::COUNT_BITS-1:0] pair_count;
	logic [glcm_pkg::TOTAL_BITS-1:0] pair_total;
	logic                            offset_error;

	modport source(output valid, pair_count, pair_total, offset_error, input ready);
	modport sink(input valid, pair_count, pair_total, offset_error, output ready);
endinterface

`default_nettype wire

@@ rtl/glcm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module glcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/glcm_scan.sv @@
// Raster scan position, pair geometry and line delay addressing.
`default_nettype none

module glcm_scan (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire glcm_pkg::cfg_t         cfg,
	input  wire glcm_pkg::scan_ctl_t    ctl,
	output glcm_pkg::scan_stat_t        stat
);

	logic [glcm_pkg::POS_BITS-1:0]    row_q;
	logic [glcm_pkg::POS_BITS-1:0]    col_q;
	logic                             done_q;
	logic [glcm_pkg::DELAY_AW-1:0]    ptr_q;
	logic                             pair_ok_q;
	logic                             fwd_q;
	logic [glcm_pkg::DELAY_AW-1:0]    dist_q;

	logic                                    take;
	logic                                    fwd;
	logic signed [glcm_pkg::SPOS_BITS-1:0]   dr_x;
	logic signed [glcm_pkg::SPOS_BITS-1:0]   dc_x;
	logic signed [glcm_pkg::SPOS_BITS-1:0]   row_x;
	logic signed [glcm_pkg::SPOS_BITS-1:0]   col_x;
	logic signed [glcm_pkg::SPOS_BITS-1:0]   rows_x;
	logic signed [glcm_pkg::SPOS_BITS-1:0]   cols_x;
	logic signed [glcm_pkg::SPOS_BITS-1:0]   orow;
	logic signed [glcm_pkg::SPOS_BITS-1:0]   ocol;
	logic signed [glcm_pkg::PROD_BITS-1:0]   prod;
	logic signed [glcm_pkg::DIST_SBITS-1:0]  dsum;
	logic [glcm_pkg::PROD_BITS-1:0]          dmag;
	logic                                    dist_ok;
	logic                                    pair_ok;
	logic [glcm_pkg::DIM_BITS-1:0]           col_next;
	logic [glcm_pkg::DIM_BITS-1:0]           row_next;
	logic [glcm_pkg::DELAY_AW:0]             slot_sum;
	logic [glcm_pkg::DELAY_AW:0]             slot_wrap;

	// Whether the next pixel belongs to the current image.
	assign take = !done_q && !glcm_pkg::cfg_invalid(cfg) &&
	              ({1'b0, row_q} < cfg.image_rows) && ({1'b0, col_q} < cfg.image_cols);

	// Position of the partner pixel and its distance back in raster order.
	always_comb begin
		dr_x   = glcm_pkg::SPOS_BITS'(cfg.offset_rows);
		dc_x   = glcm_pkg::SPOS_BITS'(cfg.offset_cols);
		row_x  = signed'({{(glcm_pkg::SPOS_BITS - glcm_pkg::POS_BITS){1'b0}}, row_q});
		col_x  = signed'({{(glcm_pkg::SPOS_BITS - glcm_pkg::POS_BITS){1'b0}}, col_q});
		rows_x = signed'({1'b0, cfg.image_rows});
		cols_x = signed'({1'b0, cfg.image_cols});
		fwd    = !cfg.offset_rows[glcm_pkg::OFS_BITS-1] &&
		         ((cfg.offset_rows != '0) ||
		          (!cfg.offset_cols[glcm_pkg::OFS_BITS-1] && (cfg.offset_cols != '0)));
		orow   = fwd ? (row_x - dr_x) : (row_x + dr_x);
		ocol   = fwd ? (col_x - dc_x) : (col_x + dc_x);
		prod   = glcm_pkg::PROD_BITS'(cfg.offset_rows) * glcm_pkg::PROD_BITS'(cols_x);
		dsum   = glcm_pkg::DIST_SBITS'(prod) + glcm_pkg::DIST_SBITS'(cfg.offset_cols);
		dmag   = dsum[glcm_pkg::DIST_SBITS-1] ? glcm_pkg::PROD_BITS'(-dsum)
		                                      : glcm_pkg::PROD_BITS'(dsum);
		dist_ok = (dmag != '0) && (dmag <= glcm_pkg::PROD_BITS'(glcm_pkg::DELAY_DEPTH));
		pair_ok = !orow[glcm_pkg::SPOS_BITS-1] && (orow < rows_x) &&
		          !ocol[glcm_pkg::SPOS_BITS-1] && (ocol < cols_x) && dist_ok;
		col_next = glcm_pkg::DIM_BITS'(col_q) + 1'b1;
		row_next = glcm_pkg::DIM_BITS'(row_q) + 1'b1;
	end

	// Scan position and pair decision, taken once per pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			done_q    <= 1'b0;
			pair_ok_q <= 1'b0;
			fwd_q     <= 1'b0;
		end else if (ctl.start) begin
			row_q  <= '0;
			col_q  <= '0;
			done_q <= 1'b0;
		end else if (ctl.calc && take) begin
			pair_ok_q <= pair_ok;
			fwd_q     <= fwd;
			if (col_next < cfg.image_cols) begin
				col_q <= glcm_pkg::POS_BITS'(col_next);
			end else if (row_next < cfg.image_rows) begin
				col_q <= '0;
				row_q <= glcm_pkg::POS_BITS'(row_next);
			end else begin
				done_q <= 1'b1;
			end
		end
	end

	// Distance kept for the slot computation.
	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			dist_q <= glcm_pkg::DELAY_AW'(dmag);
		end
	end

	// Line delay write pointer, wrapping at the store depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctl.start) begin
			ptr_q <= '0;
		end else if (ctl.step) begin
			if (ptr_q == glcm_pkg::DELAY_AW'(glcm_pkg::DELAY_DEPTH - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Slot of the partner pixel: pointer minus distance, modulo the depth.
	always_comb begin
		slot_sum  = {1'b0, ptr_q} + (glcm_pkg::DELAY_AW + 1)'(glcm_pkg::DELAY_DEPTH) -
		            {1'b0, dist_q};
		slot_wrap = slot_sum - (glcm_pkg::DELAY_AW + 1)'(glcm_pkg::DELAY_DEPTH);
	end

	always_comb begin
		stat.take    = take;
		stat.pair_ok = pair_ok_q;
		stat.fwd     = fwd_q;
		stat.rd_slot = (slot_sum >= (glcm_pkg::DELAY_AW + 1)'(glcm_pkg::DELAY_DEPTH))
		               ? slot_wrap[glcm_pkg::DELAY_AW-1:0] : slot_sum[glcm_pkg::DELAY_AW-1:0];
		stat.wr_slot = ptr_q;
	end

endmodule

`default_nettype wire

@@ rtl/glcm_pair_histogram.sv @@
// Top level: sequencer, configuration, pair total, result register and the two memories.
`default_nettype none

// Gray-level co-occurrence histogram. Command beats carry either a raster pixel, a read of
// one table entry or an image start. One beat is worked on at a time. A pixel beat that
// completes a pair goes through a delay store read, a table read and a table write; one
// that completes none skips the table read and write, and an ignored one skips all three.
// A read beat reads the table and returns one result beat; its count is cleared in the
// table as the result is loaded into the output register. A start beat is taken without
// leaving the idle state. The result register lets a later beat be accepted while a result
// still waits, but a following read waits until the earlier result has been taken. After
// reset the 65536-entry table is cleared one entry per cycle, so no beat is accepted until
// the clearing pass finishes; configuration writes are taken at any time.
module glcm_pair_histogram (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [glcm_pkg::REG_BITS-1:0]    cfg_index,
	input  wire logic [glcm_pkg::CFG_BITS-1:0]    cfg_data,
	glcm_req_if.sink                              req,
	glcm_rsp_if.source                            rsp
);

	glcm_pkg::state_t     state_q;
	glcm_pkg::state_t     state_d;
	glcm_pkg::cfg_t       cfg_q;
	glcm_pkg::scan_ctl_t  scan_ctl;
	glcm_pkg::scan_stat_t scan_stat;

	logic                                clr_busy_q;
	logic [glcm_pkg::TABLE_AW-1:0]       clr_addr_q;
	logic [glcm_pkg::LEVEL_BITS-1:0]     pix_q;
	logic [glcm_pkg::LEVEL_BITS-1:0]     first_q;
	logic [glcm_pkg::LEVEL_BITS-1:0]     second_q;
	logic [glcm_pkg::TABLE_AW-1:0]       idx_q;
	logic [glcm_pkg::TOTAL_BITS-1:0]     total_q;
	logic                                out_valid_q;
	logic [glcm_pkg::COUNT_BITS-1:0]     out_count_q;
	logic [glcm_pkg::TOTAL_BITS-1:0]     out_total_q;
	logic                                out_error_q;

	logic                                accept;
	logic                                out_free;
	logic                                out_load;
	logic [glcm_pkg::LEVEL_BITS-1:0]     dly_rdata;
	logic                                dly_re;
	logic                                dly_we;
	logic [glcm_pkg::COUNT_BITS-1:0]     tbl_rdata;
	logic                                tbl_re;
	logic [glcm_pkg::TABLE_AW-1:0]       tbl_raddr;
	logic                                tbl_we;
	logic [glcm_pkg::TABLE_AW-1:0]       tbl_waddr;
	logic [glcm_pkg::COUNT_BITS-1:0]     tbl_wdata;

	assign req.ready = (state_q == glcm_pkg::ST_IDLE) && !clr_busy_q;
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_rows <= glcm_pkg::OFS_BITS'(1);
			cfg_q.offset_cols <= '0;
			cfg_q.image_rows  <= glcm_pkg::DIM_BITS'(glcm_pkg::MAX_ROWS);
			cfg_q.image_cols  <= glcm_pkg::DIM_BITS'(glcm_pkg::MAX_COLS);
		end else if (cfg_we) begin
			case (cfg_index)
				glcm_pkg::REG_OFFSET_ROWS: cfg_q.offset_rows <= cfg_data[glcm_pkg::OFS_BITS-1:0];
				glcm_pkg::REG_OFFSET_COLS: cfg_q.offset_cols <= cfg_data[glcm_pkg::OFS_BITS-1:0];
				glcm_pkg::REG_IMAGE_ROWS:  cfg_q.image_rows  <= cfg_data;
				glcm_pkg::REG_IMAGE_COLS:  cfg_q.image_cols  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Table clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_d        = state_q;
		scan_ctl.start = 1'b0;
		scan_ctl.calc  = 1'b0;
		scan_ctl.step  = 1'b0;
		dly_re         = 1'b0;
		dly_we         = 1'b0;
		tbl_re         = 1'b0;
		tbl_raddr      = {first_q, second_q};
		tbl_we         = 1'b0;
		tbl_waddr      = idx_q;
		tbl_wdata      = '0;
		out_load       = 1'b0;
		case (state_q)
			glcm_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.cmd)
						glcm_pkg::CMD_PIXEL: state_d = glcm_pkg::ST_PX_CALC;
						glcm_pkg::CMD_READ:  state_d = glcm_pkg::ST_RD_READ;
						glcm_pkg::CMD_START: scan_ctl.start = 1'b1;
						default: ;
					endcase
				end
			end
			glcm_pkg::ST_PX_CALC: begin
				scan_ctl.calc = 1'b1;
				state_d = scan_stat.take ? glcm_pkg::ST_PX_SLOT : glcm_pkg::ST_IDLE;
			end
			glcm_pkg::ST_PX_SLOT: begin
				dly_re  = 1'b1;
				state_d = glcm_pkg::ST_PX_WR;
			end
			glcm_pkg::ST_PX_WR: begin
				dly_we        = 1'b1;
				scan_ctl.step = 1'b1;
				tbl_raddr     = scan_stat.fwd ? {dly_rdata, pix_q} : {pix_q, dly_rdata};
				tbl_re        = scan_stat.pair_ok;
				state_d = scan_stat.pair_ok ? glcm_pkg::ST_PX_INC : glcm_pkg::ST_IDLE;
			end
			glcm_pkg::ST_PX_INC: begin
				tbl_we    = (tbl_rdata != glcm_pkg::COUNT_MAX);
				tbl_wdata = tbl_rdata + 1'b1;
				state_d   = glcm_pkg::ST_IDLE;
			end
			glcm_pkg::ST_RD_READ: begin
				tbl_re  = 1'b1;
				state_d = glcm_pkg::ST_RD_DONE;
			end
			glcm_pkg::ST_RD_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					tbl_we   = 1'b1;
					state_d  = glcm_pkg::ST_IDLE;
				end
			end
			default: state_d = glcm_pkg::ST_IDLE;
		endcase
		// The clearing pass owns the write port until it finishes.
		if (clr_busy_q) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_addr_q;
			tbl_wdata = '0;
		end
	end

	// Beat payload and table index kept for the sequence.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q    <= req.pixel;
			first_q  <= req.first_level;
			second_q <= req.second_level;
		end
		if (tbl_re) begin
			idx_q <= tbl_raddr;
		end
	end

	// Saturating pair total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (scan_ctl.start) begin
			total_q <= '0;
		end else if ((state_q == glcm_pkg::ST_PX_INC) && (total_q != glcm_pkg::TOTAL_MAX)) begin
			total_q <= total_q + 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_count_q <= tbl_rdata;
			out_total_q <= total_q;
			out_error_q <= glcm_pkg::cfg_invalid(cfg_q);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.pair_count   = out_count_q;
	assign rsp.pair_total   = out_total_q;
	assign rsp.offset_error = out_error_q;

	glcm_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctl    (scan_ctl),
		.stat   (scan_stat)
	);

	// Line delay store of recent pixels.
	glcm_ram #(
		.WIDTH (glcm_pkg::LEVEL_BITS),
		.DEPTH (glcm_pkg::DELAY_DEPTH)
	) u_delay_ram (
		.clk   (clk),
		.we    (dly_we),
		.waddr (scan_stat.wr_slot),
		.wdata (pix_q),
		.re    (dly_re),
		.raddr (scan_stat.rd_slot),
		.rdata (dly_rdata)
	);

	// Co-occurrence count table.
	glcm_ram #(
		.WIDTH (glcm_pkg::COUNT_BITS),
		.DEPTH (glcm_pkg::TABLE_DEPTH)
	) u_table_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench of the co-occurrence histogram: random command beats checked against a predictor.

module testbench;
	import glcm_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 20_000;
	localparam int TARGET_BEATS  = 1950;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]            cmd;
		logic [LEVEL_BITS-1:0] pixel;
		logic [LEVEL_BITS-1:0] first_level;
		logic [LEVEL_BITS-1:0] second_level;
	} cmd_beat_t;

	typedef struct {
		logic [COUNT_BITS-1:0] pair_count;
		logic [TOTAL_BITS-1:0] pair_total;
		logic                  offset_error;
	} readout_t;

	// Predicts the histogram table, the scan and the pair total, and holds the
	// readouts that are still owed by the block.
	class cooccur_model;
		bit [COUNT_BITS-1:0] counts [TABLE_DEPTH];
		bit [LEVEL_BITS-1:0] history [DELAY_DEPTH];
		int scan_r;
		int scan_c;
		int total;
		int hist_ptr;
		bit scan_over;
		int ofs_r = 1;
		int ofs_c = 0;
		int rows = MAX_ROWS;
		int cols = MAX_COLS;
		readout_t pending_reads[$];
		int failures;

		function void set_reg(logic [REG_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
			case (idx)
			REG_OFFSET_ROWS: ofs_r = $signed(data[OFS_BITS-1:0]);
			REG_OFFSET_COLS: ofs_c = $signed(data[OFS_BITS-1:0]);
			REG_IMAGE_ROWS:  rows = int'(data);
			REG_IMAGE_COLS:  cols = int'(data);
			default: ;
			endcase
		endfunction

		function bit bad_config();
			int ar;
			int ac;
			ar = (ofs_r < 0) ? -ofs_r : ofs_r;
			ac = (ofs_c < 0) ? -ofs_c : ofs_c;
			return rows < 1 || rows > MAX_ROWS || cols < 1 || cols > MAX_COLS ||
				(ar == 0 && ac == 0) || ar > MAX_OFFSET || ac > MAX_OFFSET ||
				ar >= rows || ac >= cols;
		endfunction

		// A pair is counted when its later pixel arrives; the earlier one comes
		// from the line history, d pixels back.
		function void add_pixel(int level);
			int d;
			int orow;
			int ocol;
			int slot;
			int first;
			int second;
			int idx;
			bit ahead;
			if (scan_over || scan_r >= rows || scan_c >= cols)
				return;
			d = ofs_r * cols + ofs_c;
			ahead = d > 0;
			if (ahead) begin
				orow = scan_r - ofs_r;
				ocol = scan_c - ofs_c;
			end else begin
				orow = scan_r + ofs_r;
				ocol = scan_c + ofs_c;
				d = -d;
			end
			if (orow >= 0 && orow < rows && ocol >= 0 && ocol < cols &&
			    d > 0 && d <= DELAY_DEPTH) begin
				slot = (hist_ptr + DELAY_DEPTH - d) % DELAY_DEPTH;
				first = ahead ? int'(history[slot]) : level;
				second = ahead ? level : int'(history[slot]);
				idx = first * LEVELS + second;
				if (counts[idx] != COUNT_MAX)
					counts[idx]++;
				if (total != int'(TOTAL_MAX))
					total++;
			end
			history[hist_ptr] = LEVEL_BITS'(level);
			hist_ptr = (hist_ptr + 1) % DELAY_DEPTH;
			if (scan_c + 1 < cols) begin
				scan_c++;
			end else if (scan_r + 1 < rows) begin
				scan_c = 0;
				scan_r++;
			end else begin
				scan_over = 1'b1;
			end
		endfunction

		function void accept_beat(cmd_beat_t b);
			int idx;
			case (b.cmd)
			CMD_PIXEL: begin
				if (!bad_config())
					add_pixel(int'(b.pixel));
			end
			CMD_READ: begin
				idx = int'(b.first_level) * LEVELS + int'(b.second_level);
				pending_reads.push_back('{counts[idx], TOTAL_BITS'(total), bad_config()});
				counts[idx] = '0;
			end
			CMD_START: begin
				scan_r = 0;
				scan_c = 0;
				total = 0;
				hist_ptr = 0;
				scan_over = 1'b0;
			end
			default: ;
			endcase
		endfunction

		function void check_readout(readout_t got);
			readout_t want;
			if (pending_reads.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("readout with none expected: count %0d total %0d error %0b",
						got.pair_count, got.pair_total, got.offset_error);
				return;
			end
			want = pending_reads.pop_front();
			if (got.pair_count !== want.pair_count || got.pair_total !== want.pair_total ||
			    got.offset_error !== want.offset_error) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("readout mismatch: count %0d/%0d total %0d/%0d error %0b/%0b (got/exp)",
						got.pair_count, want.pair_count, got.pair_total, want.pair_total,
						got.offset_error, want.offset_error);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [REG_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	glcm_req_if req();
	glcm_rsp_if rsp();

	cooccur_model model = new();

	int burst_left;
	int useful;
	int palette [4];
	bit hold_req;
	int cycles;

	glcm_pair_histogram u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: check each taken beat, stall on a random pattern that is drawn anew each
	// time the phase counter wraps, and hold off once for a long stretch on request.
	initial begin
		logic [15:0] pattern;
		int phase;
		int hold_left;
		bit hold_used;
		pattern = '1;
		phase = 0;
		hold_left = 0;
		hold_used = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				model.check_readout('{rsp.pair_count, rsp.pair_total, rsp.offset_error});
			if (phase == 0) begin
				case ($urandom_range(0, 3))
				0: pattern = '1;
				1: pattern = 16'($urandom);
				2: pattern = 16'($urandom | $urandom);
				default: pattern = 16'($urandom & $urandom & $urandom);
				endcase
			end
			phase = (phase + 1) % 32;
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= pattern[phase % 16];
			end
		end
	end

	// Writes one register; the caller lowers the write enable after the last one.
	task automatic write_reg(logic [REG_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		model.set_reg(idx, data);
	endtask

	task automatic write_config(int dr, int dc, int nr, int nc);
		write_reg(REG_OFFSET_ROWS, CFG_BITS'(dr[OFS_BITS-1:0]));
		write_reg(REG_OFFSET_COLS, CFG_BITS'(dc[OFS_BITS-1:0]));
		write_reg(REG_IMAGE_ROWS, CFG_BITS'(nr));
		write_reg(REG_IMAGE_COLS, CFG_BITS'(nc));
		cfg_we <= 1'b0;
	endtask

	// Offers one command beat in bursts with random gaps and waits for it to be taken.
	task automatic send(logic [1:0] code, int level, int first, int second);
		cmd_beat_t b;
		int gap;
		b = '{code, LEVEL_BITS'(level), LEVEL_BITS'(first), LEVEL_BITS'(second)};
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.cmd <= b.cmd;
		req.pixel <= b.pixel;
		req.first_level <= b.first_level;
		req.second_level <= b.second_level;
		do @(posedge clk); while (req.ready !== 1'b1);
		model.accept_beat(b);
	endtask

	function automatic int pick_level();
		if ($urandom_range(0, 3) != 0)
			return palette[$urandom_range(0, 3)];
		return $urandom_range(0, 255);
	endfunction

	task automatic send_read();
		send(CMD_READ, $urandom_range(0, 255), pick_level(), pick_level());
	endtask

	// Stops offering and waits for every owed readout, then lets a pixel in flight finish.
	task automatic settle();
		int waited;
		req.valid <= 1'b0;
		burst_left = 0;
		waited = 0;
		while (model.pending_reads.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random image: a new setting, a start, raster pixels with reads and stray
	// beats mixed in, then a few closing reads.
	task automatic run_image();
		int nr;
		int nc;
		int dr;
		int dc;
		int dr_max;
		int dc_max;
		int n_pix;
		int roll;
		bit broken;
		broken = ($urandom_range(0, 9) == 0);
		if (broken) begin
			dr = int'($urandom_range(0, 31)) - 16;
			dc = int'($urandom_range(0, 31)) - 16;
			nr = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2047) : $urandom_range(1, 4);
			nc = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2047) : $urandom_range(1, 4);
		end else begin
			nr = ($urandom_range(0, 15) == 0) ? MAX_ROWS : $urandom_range(1, 10);
			nc = ($urandom_range(0, 15) == 0) ? MAX_COLS : $urandom_range(1, 12);
			dr_max = (nr - 1 < MAX_OFFSET) ? nr - 1 : MAX_OFFSET;
			dc_max = (nc - 1 < MAX_OFFSET) ? nc - 1 : MAX_OFFSET;
			dr = int'($urandom_range(0, 2 * dr_max)) - dr_max;
			dc = int'($urandom_range(0, 2 * dc_max)) - dc_max;
			if ($urandom_range(0, 5) == 0)
				dr = ($urandom_range(0, 1) != 0) ? dr_max : -dr_max;
			if ($urandom_range(0, 5) == 0)
				dc = ($urandom_range(0, 1) != 0) ? dc_max : -dc_max;
			if (dr == 0 && dc == 0) begin
				if (dc_max > 0)
					dc = dc_max;
				else
					dr = dr_max;
			end
		end
		settle();
		write_config(dr, dc, nr, nc);
		foreach (palette[i])
			palette[i] = ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1) :
				$urandom_range(0, 255);
		send(CMD_START, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		useful++;

		// Whole small images, a partial scan of large ones, and sometimes a few
		// pixels past the end.
		if (broken || nr * nc > 160)
			n_pix = broken ? $urandom_range(2, 10) : $urandom_range(40, 160);
		else
			n_pix = nr * nc + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
		for (int i = 0; i < n_pix; i++) begin
			send(CMD_PIXEL, ($urandom_range(0, 9) < 7) ? pick_level() : $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255));
			if (!model.bad_config() && i < nr * nc)
				useful++;
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				send_read();
				useful++;
			end else if (roll < 13) begin
				send(CMD_START, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
				useful++;
			end else if (roll < 15) begin
				send(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
			end
		end
		repeat ($urandom_range(1, 4)) begin
			send_read();
			useful++;
		end
	endtask

	initial begin
		int diag [9];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_OFFSET_ROWS;
		cfg_data = '0;
		req.valid = 1'b0;
		req.cmd = CMD_PIXEL;
		req.pixel = '0;
		req.first_level = '0;
		req.second_level = '0;
		burst_left = 0;
		useful = 0;
		diag = '{0, 255, 170, 85, 0, 255, 255, 170, 0};
		palette = '{0, 255, 170, 85};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Diagonal pairs in a 3x3 image with the gray extremes, a pixel past the
		// end, the unused command and a read that finds its entry already cleared.
		write_config(1, -1, 3, 3);
		send(CMD_START, 0, 0, 0);
		foreach (diag[i])
			send(CMD_PIXEL, diag[i], 0, 0);
		send(CMD_PIXEL, 255, 0, 0);
		send(CMD_UNUSED, 255, 255, 255);
		send(CMD_READ, 0, 255, 85);
		send(CMD_READ, 0, 0, 255);
		send(CMD_READ, 255, 255, 255);
		send(CMD_READ, 255, 255, 85);

		// Bad settings: both offsets zero, offsets beyond the limit, empty and
		// oversized images. Pixels are dropped and reads flag the error.
		settle();
		write_config(0, 0, 4, 4);
		send(CMD_PIXEL, 170, 0, 0);
		send(CMD_READ, 0, 170, 170);
		settle();
		write_config(15, -16, 4, 4);
		send(CMD_READ, 0, 0, 0);
		settle();
		write_config(1, 0, 0, 2047);
		send(CMD_READ, 0, 255, 0);

		// Shrinking the image under a scan that has already passed its new end.
		settle();
		write_config(0, 1, 4, 2);
		send(CMD_START, 0, 0, 0);
		for (int i = 0; i < 5; i++)
			send(CMD_PIXEL, (i % 2) ? 255 : 0, 0, 0);
		settle();
		write_config(0, 1, 2, 2);
		send(CMD_PIXEL, 0, 0, 0);
		send(CMD_READ, 0, 0, 255);

		// Long hold-off on the result side while reads keep coming, so the block
		// backs up into its input.
		hold_req <= 1'b1;
		repeat (6)
			send_read();

		while (useful < TARGET_BEATS)
			run_image();

		settle();
		if (model.pending_reads.size() != 0) begin
			model.failures++;
			$display("%0d readouts never arrived", model.pending_reads.size());
		end
		if (model.failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
